// ===== hdl/ccl_pkg.sv =====
package ccl_pkg;

    localparam int COUNT_BITS = 32;
    localparam int OUT_BITS   = 32;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [OUT_BITS-1:0]   t_out;

    typedef struct packed {
        logic       eof;
        logic [7:0] byte_req;
    } t_item;

    typedef struct packed {
        t_out total_lines;
        t_out total_chars;
        t_out file_lines;
        t_out file_chars;
    } t_result;

    typedef struct packed {
        logic slash_pending;
        logic inside_comment;
        logic comment_star_seen;
        logic inside_string;
        logic inside_char_literal;
        logic escape_pending;
    } t_flags;

    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic t_out to_out(input t_cnt a);
        logic [COUNT_BITS+OUT_BITS-1:0] w;
        w = {{OUT_BITS{1'b0}}, a};
        return w[OUT_BITS-1:0];
    endfunction

endpackage

// ===== hdl/c_source_char_line_counter_top.sv =====
// an end-of-file transaction passes the input and output registers before o_m_tvalid rises
// data bytes give no result and leave the core in the cycle after acceptance
// throughput: one transaction per cycle, set by the single-pass counter update
// the core stalls only when an end-of-file meets a result not yet taken
// reset: synchronous active-low i_rst_n clears all counters, flags, the mode bit and valids
module c_source_char_line_counter_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // byte_req
    input  logic         i_s_tuser,   // eof
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata    // file_chars, file_lines, total_chars, total_lines
);
    import ccl_pkg::*;

    t_item   s_item;
    t_item   in_item;
    logic    in_valid;
    logic    advance;
    logic    res_valid;
    logic    out_ready;
    t_result core_result;
    t_result out_result;
    t_flags  flags;

    assign s_item.eof      = i_s_tuser;
    assign s_item.byte_req = i_s_tdata;

    ccl_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (s_item),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    ccl_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (in_valid),
        .i_item        (in_item),
        .i_out_ready   (out_ready),
        .o_advance     (advance),
        .o_res_valid   (res_valid),
        .o_result      (core_result),
        .o_flags       (flags)
    );

    ccl_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (o_m_tvalid),
        .o_result (out_result),
        .i_ready  (i_m_tready)
    );

    assign o_m_tdata = out_result;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> out_ready)
        else $error("result produced while output register full");

    a_literal_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(flags.inside_string && flags.inside_char_literal))
        else $error("inside string and char literal at once");

    a_star_in_comment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flags.comment_star_seen |-> flags.inside_comment)
        else $error("comment star flag outside comment");

    a_slash_not_comment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(flags.slash_pending && flags.inside_comment))
        else $error("slash pending inside comment");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> (flags == '0))
        else $error("per-file flags not cleared after end of file");
`endif

endmodule

// ===== hdl/ccl_in_stage.sv =====
module ccl_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ccl_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_valid,
    output ccl_pkg::t_item o_item
);
    import ccl_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) ? 1'b1 : (i_advance ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hdl/ccl_core.sv =====
module ccl_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             i_valid,
    input  ccl_pkg::t_item   i_item,
    input  logic             i_out_ready,
    output logic             o_advance,
    output logic             o_res_valid,
    output ccl_pkg::t_result o_result,
    output ccl_pkg::t_flags  o_flags
);
    import ccl_pkg::*;

    logic   r_strip;
    t_cnt   r_char, n_char;
    t_cnt   r_line, n_line;
    t_cnt   r_cln, n_cln;
    t_cnt   r_sum_c, n_sum_c;
    t_cnt   r_sum_l, n_sum_l;
    t_flags r_flags, n_flags;

    t_cnt       v_file_c;
    t_cnt       v_char;
    logic [1:0] v_inc;
    logic       v_do_strip;
    logic       v_lit;
    logic [7:0] c;

    assign c           = i_item.byte_req;
    assign o_advance   = i_valid && (!i_item.eof || i_out_ready);
    assign o_res_valid = o_advance && i_item.eof;

    always_comb begin
        n_char     = r_char;
        n_line     = r_line;
        n_cln      = r_cln;
        n_sum_c    = r_sum_c;
        n_sum_l    = r_sum_l;
        n_flags    = r_flags;
        v_inc      = 2'd0;
        v_do_strip = 1'b0;
        v_lit      = r_flags.inside_string || r_flags.inside_char_literal;
        v_file_c   = sat_add(r_char, t_cnt'(r_flags.slash_pending));
        v_char     = r_char;

        if (i_item.eof) begin
            n_sum_c = sat_add(r_sum_c, v_file_c);
            n_sum_l = sat_add(r_sum_l, r_line);
            n_char  = '0;
            n_line  = '0;
            n_cln   = '0;
            n_flags = '0;
        end else if (!r_strip) begin
            n_char = sat_add(r_char, t_cnt'(1));
            if (c == CH_NL) begin
                n_line = sat_add(r_line, t_cnt'(1));
                n_cln  = n_char;
            end
        end else if (r_flags.escape_pending) begin
            n_flags.escape_pending = 1'b0;
        end else if (r_flags.inside_comment) begin
            if (c == CH_NUL || (r_flags.comment_star_seen && c == CH_SLASH)) begin
                n_flags.inside_comment    = 1'b0;
                n_flags.comment_star_seen = 1'b0;
            end else begin
                n_flags.comment_star_seen = (c == CH_STAR);
            end
        end else if (r_flags.slash_pending) begin
            n_flags.slash_pending = 1'b0;
            if (c == CH_STAR) begin
                n_flags.inside_comment    = 1'b1;
                n_flags.comment_star_seen = 1'b0;
            end else begin
                v_char     = v_file_c;
                v_do_strip = 1'b1;
            end
        end else begin
            v_do_strip = 1'b1;
        end

        if (v_do_strip) begin
            if (c == CH_NL) begin
                if (v_char > r_cln) begin
                    n_line = sat_add(r_line, t_cnt'(1));
                end
                n_cln = v_char;
            end
            if (!v_lit && c == CH_SLASH) begin
                n_flags.slash_pending = 1'b1;
            end else if (!v_lit && (c == CH_NL || c == CH_TAB || c == CH_SPACE)) begin
                v_inc = 2'd0;
            end else begin
                if (c == CH_DQUOTE && !r_flags.inside_char_literal) begin
                    n_flags.inside_string = !r_flags.inside_string;
                end
                if (c == CH_SQUOTE && !r_flags.inside_string) begin
                    n_flags.inside_char_literal = !r_flags.inside_char_literal;
                end
                if (c == CH_BSLASH) begin
                    v_inc                  = 2'd2;
                    n_flags.escape_pending = 1'b1;
                end else begin
                    v_inc = 2'd1;
                end
            end
            // pending slash is in v_char too; add it and this byte's count to r_char
            n_char = sat_add(r_char, t_cnt'(r_flags.slash_pending) + t_cnt'(v_inc));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip <= 1'b0;
            r_char  <= '0;
            r_line  <= '0;
            r_cln   <= '0;
            r_sum_c <= '0;
            r_sum_l <= '0;
            r_flags <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_strip <= i_cfg_wr_data;
            end
            if (o_advance) begin
                r_char  <= n_char;
                r_line  <= n_line;
                r_cln   <= n_cln;
                r_sum_c <= n_sum_c;
                r_sum_l <= n_sum_l;
                r_flags <= n_flags;
            end
        end
    end

    assign o_result.file_chars  = to_out(v_file_c);
    assign o_result.file_lines  = to_out(r_line);
    assign o_result.total_chars = to_out(n_sum_c);
    assign o_result.total_lines = to_out(n_sum_l);
    assign o_flags              = r_flags;

endmodule

// ===== hdl/ccl_out_stage.sv =====
module ccl_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ccl_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_valid,
    output ccl_pkg::t_result o_result,
    input  logic             i_ready
);
    import ccl_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = i_valid ? 1'b1 : (i_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
